[design/ftpcl_pkg.sv]
// Shared types, constants and the verb table of the FTP command line parser.
package ftpcl_pkg;

  localparam int VERB_COUNT_DEF = 32;
  localparam int TABLE_SIZE     = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [2:0] POS_MAX = 3'd5;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [1:0] VERDICT_DISPATCH = 2'd0;
  localparam logic [1:0] VERDICT_REFUSED  = 2'd1;
  localparam logic [1:0] VERDICT_INVALID  = 2'd2;

  // Byte 0 of a verb sits in bits 31:24, byte 3 in bits 7:0.
  localparam logic [31:0] VERB_TABLE [TABLE_SIZE] = '{
    "USER", "PASS", "QUIT", "REIN", {"CWD", 8'h00}, "CDUP", "RNFR", "RNTO",
    "ABOR", "DELE", {"RMD", 8'h00}, {"MKD", 8'h00}, {"PWD", 8'h00}, "LIST", "NLST", "PORT",
    "TYPE", "PASV", "RETR", "STOR", "APPE", "HELP", "NOOP", "SMNT",
    "ACCT", "STRU", "MODE", "STOU", "ALLO", "REST", "SITE", "SYST"
  };

  // 1 = four-letter verb, 0 = three-letter verb.
  localparam logic [TABLE_SIZE-1:0] VERB_IS_LEN4 = 32'b1111_1111_1111_1111_1110_0011_1110_1111;

  // One request from the front to the back: an argument byte, a verdict, or both.
  typedef struct packed {
    logic        arg_valid;
    logic [7:0]  arg_byte;
    logic        fin_valid;
    logic [31:0] verb_chars;
    logic        verb_len4;
    logic        format_error;
    logic        logged_in;
  } ftpcl_req_t;

  function automatic logic is_crlf(input logic [7:0] c);
    return (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

endpackage

[design/ftpcl_front.sv]
// Front end: tracks byte position, decides the verb length and holds back argument bytes.
module ftpcl_front import ftpcl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_line,
  input  logic       logged_in,
  input  logic       queue_full,
  output logic       push,
  output ftpcl_req_t push_req
);

  logic [2:0]  pos;
  logic [31:0] chars;
  logic        decided;
  logic        len4;
  logic        has_arg;
  logic        ferr;
  logic [7:0]  pend_byte;
  logic        pend_valid;

  logic        accept;
  logic [31:0] chars_next;
  logic        decided_next;
  logic        len4_next;
  logic        has_arg_next;
  logic        ferr_next;
  logic        past_verb;
  logic        stream_ok;
  logic        ferr_eol;
  logic        lf_ok;
  logic        emit_arg;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  always_comb begin
    chars_next   = chars;
    decided_next = decided;
    len4_next    = len4;
    has_arg_next = has_arg;
    ferr_next    = ferr;
    if (pos < 3'd4) begin
      chars_next[31 - 8 * pos -: 8] = data_byte;
    end
    if (!decided && !ferr) begin
      if (pos == 3'd3) begin
        if (data_byte == CHAR_SPACE) begin
          decided_next = 1'b1;
          len4_next    = 1'b0;
          has_arg_next = 1'b1;
        end else if (end_of_line) begin
          if (is_crlf(data_byte)) begin
            decided_next = 1'b1;
            len4_next    = 1'b0;
            has_arg_next = 1'b0;
          end else begin
            ferr_next = 1'b1;
          end
        end
      end else if (pos == 3'd4) begin
        if (data_byte == CHAR_SPACE) begin
          decided_next = 1'b1;
          len4_next    = 1'b1;
          has_arg_next = 1'b1;
        end else if (is_crlf(chars[7:0])) begin
          decided_next = 1'b1;
          len4_next    = 1'b0;
          has_arg_next = 1'b0;
        end else if (is_crlf(data_byte)) begin
          decided_next = 1'b1;
          len4_next    = 1'b1;
          has_arg_next = 1'b0;
        end else begin
          ferr_next = 1'b1;
        end
      end
    end
  end

  assign past_verb = len4_next ? (pos > 3'd4) : (pos > 3'd3);
  assign stream_ok = !ferr_next && decided_next && has_arg_next && past_verb;
  assign ferr_eol  = ferr_next || !decided_next;
  assign lf_ok     = data_byte == CHAR_LF;

  always_comb begin
    if (end_of_line) begin
      emit_arg = !ferr_eol && has_arg_next && lf_ok && pend_valid && (pend_byte != CHAR_CR);
    end else begin
      emit_arg = stream_ok && pend_valid;
    end
  end

  assign push = accept && (emit_arg || end_of_line);

  always_comb begin
    push_req.arg_valid    = emit_arg;
    push_req.arg_byte     = pend_byte;
    push_req.fin_valid    = end_of_line;
    push_req.verb_chars   = chars_next;
    push_req.verb_len4    = len4_next;
    push_req.format_error = ferr_eol || (has_arg_next && !lf_ok);
    push_req.logged_in    = logged_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 3'd0;
      chars      <= '0;
      decided    <= 1'b0;
      len4       <= 1'b0;
      has_arg    <= 1'b0;
      ferr       <= 1'b0;
      pend_byte  <= 8'd0;
      pend_valid <= 1'b0;
    end else if (accept) begin
      if (end_of_line) begin
        // clear for the next line
        pos        <= 3'd0;
        chars      <= '0;
        decided    <= 1'b0;
        len4       <= 1'b0;
        has_arg    <= 1'b0;
        ferr       <= 1'b0;
        pend_byte  <= 8'd0;
        pend_valid <= 1'b0;
      end else begin
        pos     <= (pos == POS_MAX) ? pos : pos + 3'd1;
        chars   <= chars_next;
        decided <= decided_next;
        len4    <= len4_next;
        has_arg <= has_arg_next;
        ferr    <= ferr_next;
        if (stream_ok) begin
          pend_byte  <= data_byte;
          pend_valid <= 1'b1;
        end
      end
    end
  end

endmodule

[design/ftpcl_queue.sv]
// Short request queue between the front end and the back end.
module ftpcl_queue import ftpcl_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ftpcl_req_t push_req,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output ftpcl_req_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ftpcl_req_t       entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_push;
  logic do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/ftpcl_back.sv]
// Back end: looks up the verb, forms the verdict and drives the output register.
module ftpcl_back import ftpcl_pkg::*; #(
  parameter int VERB_COUNT = VERB_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  ftpcl_req_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_final,
  output logic [7:0] arg_byte,
  output logic [4:0] command_index,
  output logic [1:0] verdict
);

  localparam int LIMIT = (VERB_COUNT < TABLE_SIZE) ? VERB_COUNT : TABLE_SIZE;

  logic       arg_done;
  logic       load;
  logic       take;
  logic       send_arg;
  logic       found;
  logic [4:0] match_idx;
  logic [1:0] verdict_next;
  logic [4:0] index_next;

  // Lowest matching index wins.
  always_comb begin
    found     = 1'b0;
    match_idx = 5'd0;
    for (int i = LIMIT - 1; i >= 0; i--) begin
      if (VERB_IS_LEN4[i] == head.verb_len4) begin
        if (head.verb_len4 ? (head.verb_chars == VERB_TABLE[i])
                           : (head.verb_chars[31:8] == VERB_TABLE[i][31:8])) begin
          found     = 1'b1;
          match_idx = 5'(i);
        end
      end
    end
    if (head.format_error) begin
      found = 1'b0;
    end
  end

  always_comb begin
    index_next = 5'd0;
    if (!head.logged_in && !(found && match_idx == 5'd0)) begin
      verdict_next = VERDICT_REFUSED;
    end else if (!found) begin
      verdict_next = VERDICT_INVALID;
    end else begin
      verdict_next = VERDICT_DISPATCH;
      index_next   = match_idx;
    end
  end

  assign load     = !out_valid || !out_stall;
  assign take     = load && !empty;
  assign send_arg = head.arg_valid && !arg_done;
  // hold the request while its argument byte goes out first
  assign pop      = take && !(send_arg && head.fin_valid);

  always_ff @(posedge clk) begin
    if (take) begin
      if (send_arg) begin
        is_final      <= 1'b0;
        arg_byte      <= head.arg_byte;
        command_index <= 5'd0;
        verdict       <= VERDICT_DISPATCH;
      end else begin
        is_final      <= 1'b1;
        arg_byte      <= 8'd0;
        command_index <= index_next;
        verdict       <= verdict_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      arg_done  <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        arg_done  <= send_arg && head.fin_valid;
      end else if (load) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/ftp_command_line_parser.sv]
// FTP command line parser top level: front end, request queue and back end.
// Path: the byte that releases a result is written into the request queue, and the result
// then leaves through the output register. The queue holds QUEUE_DEPTH requests.
// Throughput: one byte per cycle while the queue is not full. A line's last byte that also
// releases an argument byte fills the output register first with that byte, then the verdict.
// Reset (rst, synchronous): clears the line state, empties the queue, drops out_valid.
module ftp_command_line_parser import ftpcl_pkg::*; #(
  parameter int VERB_COUNT = VERB_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_line,
  input  logic       logged_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_final,
  output logic [7:0] arg_byte,
  output logic [4:0] command_index,
  output logic [1:0] verdict
);

  logic       push;
  ftpcl_req_t push_req;
  logic       queue_full;
  logic       pop;
  logic       empty;
  ftpcl_req_t head;

  ftpcl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_line (end_of_line),
    .logged_in   (logged_in),
    .queue_full  (queue_full),
    .push        (push),
    .push_req    (push_req)
  );

  ftpcl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (queue_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  ftpcl_back #(
    .VERB_COUNT (VERB_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_final      (is_final),
    .arg_byte      (arg_byte),
    .command_index (command_index),
    .verdict       (verdict)
  );

endmodule
